[hw/rtl/iirbp_pkg.sv]
// iirbp_pkg: widths, reset values and register indexes for the 4-pole band-pass filter
// no dependencies; imported by iir_bandpass_order4_top
`timescale 1ns / 1ps

package iirbp_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SCALE_W  = 48;
    localparam int TAP_W    = 36;
    localparam int XH_W     = 48;   // scaled input, 40 fraction bits
    localparam int YH_W     = 64;   // output history, Q24.40
    localparam int FF_W     = XH_W + 3;
    localparam int ACC_W    = 103;  // exact sum, 72 fraction bits
    localparam int NUM_TAPS = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    typedef logic signed [XH_W-1:0]  t_xh;
    typedef logic signed [YH_W-1:0]  t_yh;
    typedef logic signed [TAP_W-1:0] t_tap;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_SCALE = 3'd0,
        CFG_TAP4        = 3'd1,
        CFG_TAP3        = 3'd2,
        CFG_TAP2        = 3'd3,
        CFG_TAP1        = 3'd4
    } t_cfg_idx;

    localparam logic [SCALE_W-1:0] SCALE_RST = 48'd91401506;
    localparam t_tap TAP4_RST = -36'sd4288049685;
    localparam t_tap TAP3_RST = 36'sd17159092476;
    localparam t_tap TAP2_RST = -36'sd25749003192;
    localparam t_tap TAP1_RST = 36'sd17172927696;

endpackage

[hw/rtl/iir_bandpass_order4_top.sv]
// iir_bandpass_order4_top: 4-pole butterworth band-pass, direct form I, fixed point
// depends on iirbp_pkg
//
//  channel   direction  handshake              payload
//  input     in         i_valid / o_ready      i_sample_in
//  output    out        o_valid / i_ready      o_sample_out, o_clipped
//  config    in         i_cfg_wr_en            i_cfg_idx, i_cfg_data
//
// one beat per cycle sustained while the output is not stalled
// stage 1 holds the sample, stage 2 the scaled and combined feed-forward term,
// the output register the rounded result
// the rate is set by the feedback loop: the four tap products on past outputs and
// their sum close combinationally in the second stage, from r_yh back into r_yh[0]
// synchronous active-low reset clears history and valid flags and loads config with its reset values
// a stalled output backs up the stages in turn; input stays ready while any stage is free
`timescale 1ns / 1ps

module iir_bandpass_order4_top
    import iirbp_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [SAMPLE_W-1:0]   i_sample_in,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [SAMPLE_W-1:0]   o_sample_out,
    output logic                         o_clipped
);

    // configuration
    logic [SCALE_W-1:0] r_scale;
    t_tap               r_tap [NUM_TAPS];   // r_tap[k] weights y[n-1-k]

    // pipeline
    logic                        r_s1_valid;
    logic signed [SAMPLE_W-1:0]  r_smp;
    logic                        r_s2_valid;
    logic signed [FF_W-1:0]      r_ff;
    logic                        r_out_valid;
    logic signed [SAMPLE_W-1:0]  r_out_sample;
    logic                        r_out_clip;

    t_xh r_xh [NUM_TAPS];
    t_yh r_yh [NUM_TAPS];

    logic s1_adv, s2_adv, s2_ready, in_acc;

    assign s2_adv   = r_s2_valid && (!r_out_valid || i_ready);
    assign s2_ready = !r_s2_valid || s2_adv;
    assign s1_adv   = r_s1_valid && s2_ready;
    assign o_ready  = !r_s1_valid || s1_adv;
    assign in_acc   = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= SCALE_RST;
            r_tap[0] <= TAP1_RST;
            r_tap[1] <= TAP2_RST;
            r_tap[2] <= TAP3_RST;
            r_tap[3] <= TAP4_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_INPUT_SCALE: r_scale  <= i_cfg_data[SCALE_W-1:0];
                CFG_TAP4:        r_tap[3] <= $signed(i_cfg_data[TAP_W-1:0]);
                CFG_TAP3:        r_tap[2] <= $signed(i_cfg_data[TAP_W-1:0]);
                CFG_TAP2:        r_tap[1] <= $signed(i_cfg_data[TAP_W-1:0]);
                CFG_TAP1:        r_tap[0] <= $signed(i_cfg_data[TAP_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    // stage 1 -> 2: scale the sample, round to 40 fraction bits, saturate to 48
    logic signed [SAMPLE_W+SCALE_W:0] w_prod;
    logic signed [SAMPLE_W+SCALE_W:0] w_rnd;
    logic signed [SAMPLE_W+SCALE_W-8:0] w_shr;
    t_xh                              w_x;
    logic signed [FF_W-1:0]           n_ff;

    always_comb begin
        w_prod = r_smp * $signed({1'b0, r_scale});
        w_rnd  = w_prod + (SAMPLE_W+SCALE_W+1)'(128);
        w_shr  = w_rnd[SAMPLE_W+SCALE_W:8];
        if (w_shr[SAMPLE_W+SCALE_W-8:XH_W-1] == '0
            || w_shr[SAMPLE_W+SCALE_W-8:XH_W-1] == '1) begin
            w_x = w_shr[XH_W-1:0];
        end else if (w_shr[SAMPLE_W+SCALE_W-8]) begin
            w_x = {1'b1, {(XH_W-1){1'b0}}};
        end else begin
            w_x = {1'b0, {(XH_W-1){1'b1}}};
        end
        // x[n] + x[n-4] - 2*x[n-2]
        n_ff = FF_W'(w_x) + FF_W'(r_xh[3]) - (FF_W'(r_xh[1]) <<< 1);
    end

    // stage 2 -> out: feedback taps, split as 36x32 partial products per tap
    logic signed [TAP_W+32-1:0] w_pp_hi [NUM_TAPS];
    logic signed [TAP_W+33-1:0] w_pp_lo [NUM_TAPS];
    logic signed [ACC_W-1:0]    w_term  [NUM_TAPS];
    logic signed [ACC_W-1:0]    w_acc;
    logic signed [ACC_W-33:0]   w_ysh;
    t_yh                        w_y;
    logic signed [YH_W-40:0]    w_q;
    logic signed [SAMPLE_W-1:0] n_sample;
    logic                       n_clip;

    always_comb begin
        for (int k = 0; k < NUM_TAPS; k++) begin
            w_pp_hi[k] = r_tap[k] * $signed(r_yh[k][YH_W-1:32]);
            w_pp_lo[k] = r_tap[k] * $signed({1'b0, r_yh[k][31:0]});
            w_term[k]  = (ACC_W'(w_pp_hi[k]) <<< 32) + ACC_W'(w_pp_lo[k]);
        end
        w_acc = (ACC_W'(r_ff) <<< 32) + w_term[0] + w_term[1] + w_term[2] + w_term[3]
                + ACC_W'(64'sh8000_0000);
        w_ysh = w_acc[ACC_W-1:32];
        if (w_ysh[ACC_W-33:YH_W-1] == '0 || w_ysh[ACC_W-33:YH_W-1] == '1) begin
            w_y = w_ysh[YH_W-1:0];
        end else if (w_ysh[ACC_W-33]) begin
            w_y = {1'b1, {(YH_W-1){1'b0}}};
        end else begin
            w_y = {1'b0, {(YH_W-1){1'b1}}};
        end
        // round half up to integer
        w_q = $signed({w_y[YH_W-1], w_y[YH_W-1:40]})
              + $signed({{(YH_W-40){1'b0}}, w_y[39]});
        if (w_q[YH_W-40:SAMPLE_W-1] == '0 || w_q[YH_W-40:SAMPLE_W-1] == '1) begin
            n_sample = w_q[SAMPLE_W-1:0];
            n_clip   = 1'b0;
        end else if (w_q[YH_W-40]) begin
            n_sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
            n_clip   = 1'b1;
        end else begin
            n_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
            n_clip   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_TAPS; k++) begin
                r_xh[k] <= '0;
                r_yh[k] <= '0;
            end
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_valid <= 1'b1;
                r_xh[0]    <= w_x;
                for (int k = 1; k < NUM_TAPS; k++) begin
                    r_xh[k] <= r_xh[k-1];
                end
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_adv) begin
                r_out_valid <= 1'b1;
                r_yh[0]     <= w_y;
                for (int k = 1; k < NUM_TAPS; k++) begin
                    r_yh[k] <= r_yh[k-1];
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_smp <= i_sample_in;
        end
        if (s1_adv) begin
            r_ff <= n_ff;
        end
        if (s2_adv) begin
            r_out_sample <= n_sample;
            r_out_clip   <= n_clip;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_clipped    = r_out_clip;

    a_clip_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clipped) |-> (o_sample_out == 16'sh7fff || o_sample_out == -16'sh8000))
        else $error("clipped set on a sample that is not at a rail");

    a_yh_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_adv |=> (r_yh[1] == $past(r_yh[0]) && r_yh[3] == $past(r_yh[2])))
        else $error("output history did not shift with the result");

    a_xh_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_adv |=> (r_xh[0] == $past(r_xh[0]) && r_xh[3] == $past(r_xh[3])))
        else $error("input history moved without a stage advance");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !s2_adv) |-> !s1_adv)
        else $error("stage 2 overwritten while held");

    a_in_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted beat not held in stage 1");

endmodule

[tb/tb.sv]
// tb: self-checking bench for iir_bandpass_order4_top, with its own fixed-point filter model
// depends on iirbp_pkg and iir_bandpass_order4_top; drives valid/ready with random bursts and stalls
`timescale 1ns / 1ps

module tb;
    import iirbp_pkg::*;

    localparam int RESET_CYCLES = 9;
    localparam int PIPE_SETTLE  = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 500;
    localparam int FLUSH_LEN    = 8;

    localparam t_tap TAP_MAX = {1'b0, {(TAP_W-1){1'b1}}};
    localparam t_tap TAP_MIN = {1'b1, {(TAP_W-1){1'b0}}};
    localparam t_tap TAP_ZERO = '0;
    localparam logic [SCALE_W-1:0] SCALE_MAX = '1;
    localparam logic [SCALE_W-1:0] SCALE_ZERO = '0;
    localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 16'sh8000;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clipped;
    } filt_out_t;

    typedef enum int {RX_STEADY, RX_COIN, RX_RUNS} rx_mode_t;
    typedef enum int {STIM_NOISE, STIM_TONE, STIM_QUIET} stim_style_t;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]        i_cfg_idx;
    logic [CFG_DATA_W-1:0]       i_cfg_data;
    logic                        i_valid;
    logic                        o_ready;
    logic signed [SAMPLE_W-1:0]  i_sample_in;
    logic                        o_valid;
    logic                        i_ready;
    logic signed [SAMPLE_W-1:0]  o_sample_out;
    logic                        o_clipped;

    // filter model state
    logic [SCALE_W-1:0] gain_recip;
    t_tap               fb_tap [NUM_TAPS];     // entry k weighs y[n-1-k]
    t_xh                x_hist [NUM_TAPS];
    t_yh                y_hist [NUM_TAPS];

    filt_out_t   expected_out[$];
    int          mismatches    = 0;
    int          items_sent    = 0;
    int          beats_checked = 0;
    int          clips_seen    = 0;
    int          reg_writes    = 0;
    int unsigned cycle_count   = 0;

    rx_mode_t rx_mode      = RX_STEADY;
    int       rx_mode_left = 0;
    int       rx_run_left  = 0;
    logic     rx_run_level = 1'b1;

    iir_bandpass_order4_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sample_in  (i_sample_in),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // one filter step: scale, feed-forward, feedback, round and clamp
    function automatic filt_out_t filter_step(input logic signed [SAMPLE_W-1:0] s);
        logic signed [127:0] wide_s;
        logic signed [127:0] wide_g;
        logic signed [127:0] acc;
        t_xh                 x;
        t_yh                 y;
        logic signed [63:0]  q;
        filt_out_t           r;
        wide_s = 128'(s);
        wide_g = {80'd0, gain_recip};
        acc = (wide_s * wide_g + 128'sd128) >>> 8;
        if (acc > 128'sh7FFF_FFFF_FFFF)
            x = 48'sh7FFF_FFFF_FFFF;
        else if (acc < -128'sh8000_0000_0000)
            x = 48'sh8000_0000_0000;
        else
            x = acc[XH_W-1:0];

        acc = 128'(x);
        acc = acc + x_hist[3] - 2 * x_hist[1];
        acc = acc <<< 32;
        for (int k = 0; k < NUM_TAPS; k++)
            acc = acc + fb_tap[k] * y_hist[k];
        acc = (acc + 128'sh8000_0000) >>> 32;
        if (acc > 128'sh7FFF_FFFF_FFFF_FFFF)
            y = 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (acc < -128'sh8000_0000_0000_0000)
            y = 64'sh8000_0000_0000_0000;
        else
            y = acc[YH_W-1:0];

        for (int k = NUM_TAPS - 1; k > 0; k--) begin
            x_hist[k] = x_hist[k-1];
            y_hist[k] = y_hist[k-1];
        end
        x_hist[0] = x;
        y_hist[0] = y;

        // Q24.40 to integer, half up
        q = y >>> 40;
        if (y[39])
            q = q + 64'sd1;
        r.clipped = 1'b0;
        if (q > 64'sd32767) begin
            r.sample  = SMP_MAX;
            r.clipped = 1'b1;
        end else if (q < -64'sd32768) begin
            r.sample  = SMP_MIN;
            r.clipped = 1'b1;
        end else begin
            r.sample = q[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_sample_in <= s;
        do @(posedge i_clk); while (!o_ready);
        expected_out.push_back(filter_step(s));
        items_sent++;
    endtask

    task automatic sender_idle(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    task automatic wait_results_done();
        sender_idle(1);
        while (expected_out.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_INPUT_SCALE: gain_recip = data;
            CFG_TAP4:        fb_tap[3]  = data[TAP_W-1:0];
            CFG_TAP3:        fb_tap[2]  = data[TAP_W-1:0];
            CFG_TAP2:        fb_tap[1]  = data[TAP_W-1:0];
            CFG_TAP1:        fb_tap[0]  = data[TAP_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // upper data bits above the tap width are junk and must be dropped
    task automatic set_taps(input t_tap t1, input t_tap t2, input t_tap t3, input t_tap t4);
        write_reg(CFG_TAP1, {12'($urandom), t1});
        write_reg(CFG_TAP2, {12'($urandom), t2});
        write_reg(CFG_TAP3, {12'($urandom), t3});
        write_reg(CFG_TAP4, {12'($urandom), t4});
    endtask

    // zero taps and zero input wash both histories out
    task automatic clear_history();
        wait_results_done();
        set_taps(TAP_ZERO, TAP_ZERO, TAP_ZERO, TAP_ZERO);
        repeat (FLUSH_LEN) send_sample('0);
        wait_results_done();
    endtask

    task automatic test_reset_response();
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample(16'sd0);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sh5555);
        wait_results_done();
    endtask

    task automatic test_unused_reg_index();
        for (int i = int'(CFG_TAP1) + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), '1);
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample(16'sh2AAA);
        wait_results_done();
    endtask

    task automatic test_scale_extremes();
        clear_history();
        // zero scale keeps everything at zero whatever the taps
        write_reg(CFG_INPUT_SCALE, SCALE_ZERO);
        set_taps(TAP_MAX, TAP_MAX, TAP_MAX, TAP_MAX);
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        wait_results_done();
        set_taps(TAP_MIN, TAP_MIN, TAP_MIN, TAP_MIN);
        send_sample(SMP_MIN);
        wait_results_done();
        // full scale drives the scaled input into its own saturation
        set_taps(TAP_ZERO, TAP_ZERO, TAP_ZERO, TAP_ZERO);
        write_reg(CFG_INPUT_SCALE, SCALE_MAX);
        send_sample(SMP_MAX);
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample(SMP_MIN);
        send_sample(16'sd200);
        wait_results_done();
    endtask

    task automatic test_runaway_feedback();
        clear_history();
        write_reg(CFG_INPUT_SCALE, SCALE_MAX);
        set_taps(TAP_MAX, TAP_ZERO, TAP_ZERO, TAP_ZERO);
        send_sample(SMP_MAX);
        repeat (6) send_sample('0);
        clear_history();
        // negative gain alternates sign, hitting both rails
        set_taps(TAP_MIN, TAP_ZERO, TAP_ZERO, TAP_ZERO);
        send_sample(SMP_MIN);
        repeat (6) send_sample('0);
        clear_history();
    endtask

    task automatic test_random_stream();
        int                          seg_len;
        int                          pause_at;
        int                          period;
        int                          amp;
        int                          burst_left;
        int                          v;
        int                          kind;
        int                          sent;
        bit                          wild;
        bit                          do_pause;
        bit                          first;
        stim_style_t                 style;
        logic signed [SAMPLE_W-1:0]  s;
        t_tap                        taps [NUM_TAPS];
        sent       = 0;
        wild       = 1'b0;
        first      = 1'b1;
        burst_left = $urandom_range(1, 20);
        while (sent < RANDOM_ITEMS) begin
            if (wild)
                clear_history();
            else
                wait_results_done();
            kind = $urandom_range(0, 9);
            wild = (kind >= 8);
            if (kind < 5) begin
                write_reg(CFG_INPUT_SCALE, SCALE_RST << $urandom_range(0, 14));
                set_taps(TAP1_RST, TAP2_RST, TAP3_RST, TAP4_RST);
            end else begin
                write_reg(CFG_INPUT_SCALE, SCALE_W'({$urandom, $urandom}));
                for (int k = 0; k < NUM_TAPS; k++) begin
                    if (wild) begin
                        if ($urandom_range(0, 7) == 0)
                            taps[k] = $urandom_range(0, 1) ? TAP_MAX : TAP_MIN;
                        else
                            taps[k] = TAP_W'({$urandom, $urandom});
                    end else begin
                        // each tap within +-0.25 keeps the loop stable
                        v = $urandom_range(0, 2147483647);
                        taps[k] = TAP_W'(v - 1073741824);
                    end
                end
                set_taps(taps[0], taps[1], taps[2], taps[3]);
            end

            style    = stim_style_t'($urandom_range(0, 2));
            period   = $urandom_range(2, 40);
            amp      = $urandom_range(1000, 32700);
            seg_len  = $urandom_range(30, 90);
            pause_at = $urandom_range(0, seg_len - 1);
            do_pause = first || ($urandom_range(0, 2) == 0);
            first    = 1'b0;
            for (int i = 0; i < seg_len; i++) begin
                case (style)
                    STIM_TONE: begin
                        v = ((i / period) % 2) ? amp : -amp;
                        v = v + int'($urandom_range(0, 63)) - 32;
                        s = SAMPLE_W'(v);
                    end
                    STIM_QUIET: begin
                        v = int'($urandom_range(0, 16)) - 8;
                        s = SAMPLE_W'(v);
                    end
                    default: begin
                        if ($urandom_range(0, 7) == 0)
                            s = $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
                        else
                            s = SAMPLE_W'($urandom);
                    end
                endcase
                send_sample(s);
                sent++;
                if (do_pause && i == pause_at) begin
                    wait_results_done();
                end else if (burst_left == 0) begin
                    sender_idle($urandom_range(1, 6));
                    burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 20);
                end else begin
                    burst_left--;
                end
            end
        end
        wait_results_done();
    endtask

    // receiver stall pattern: always ready, coin flips, or long runs of each level
    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_t'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(20, 200);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            RX_STEADY: i_ready <= 1'b1;
            RX_COIN:   i_ready <= ($urandom_range(0, 3) != 0);
            default: begin
                if (rx_run_left == 0) begin
                    rx_run_level = ~rx_run_level;
                    rx_run_left  = $urandom_range(1, 12);
                end else begin
                    rx_run_left--;
                end
                i_ready <= rx_run_level;
            end
        endcase
    end

    always @(posedge i_clk) begin
        filt_out_t want;
        if (i_rst_n && o_valid && i_ready) begin
            beats_checked++;
            if (o_clipped)
                clips_seen++;
            if (expected_out.size() == 0) begin
                mismatches++;
                $display("%0t: result beat with nothing pending, sample_out %0d clipped %0b",
                         $time, o_sample_out, o_clipped);
            end else begin
                want = expected_out.pop_front();
                if (o_sample_out !== want.sample) begin
                    mismatches++;
                    $display("%0t: sample_out expected %0d got %0d",
                             $time, want.sample, o_sample_out);
                end
                if (o_clipped !== want.clipped) begin
                    mismatches++;
                    $display("%0t: clipped expected %0b got %0b",
                             $time, want.clipped, o_clipped);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results still pending",
                     $time, cycle_count, expected_out.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        i_sample_in = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        gain_recip  = SCALE_RST;
        fb_tap[0]   = TAP1_RST;
        fb_tap[1]   = TAP2_RST;
        fb_tap[2]   = TAP3_RST;
        fb_tap[3]   = TAP4_RST;
        for (int k = 0; k < NUM_TAPS; k++) begin
            x_hist[k] = '0;
            y_hist[k] = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_response();
        test_unused_reg_index();
        test_scale_extremes();
        test_runaway_feedback();
        test_random_stream();

        wait_results_done();
        $display("covered %0d samples, %0d result beats checked, %0d of them clipped",
                 items_sent, beats_checked, clips_seen);
        $display("%0d register writes over reset, extreme, stable and runaway coefficient sets",
                 reg_writes);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
